FILE: rtl/nlil_pkg.sv
// ----------------------------------------------------------------------------
// nlil_pkg
// shared types, constants and the control store for the line index lookup
// ----------------------------------------------------------------------------
package nlil_pkg;

    localparam int MAX_LINES = 4096;
    localparam int POS_BITS  = 20;
    localparam int CNT_BITS  = $clog2(MAX_LINES + 1);
    localparam int ADDR_BITS = $clog2(MAX_LINES);

    localparam logic [7:0]          NEWLINE_BYTE = 8'd10;
    localparam logic [POS_BITS-1:0] POS_MAX      = {POS_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0] CNT_FULL     = CNT_BITS'(MAX_LINES);

    // command codes on the func port
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // step counter of the sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTE,
        ST_CLEAR,
        ST_QINIT,
        ST_QTEST,
        ST_QCMP,
        ST_QDONE
    } step_t;

    // datapath operation of one control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_BYTE,
        OP_QINIT,
        OP_READ,
        OP_CMP,
        OP_DONE
    } op_t;

    // sequencing of one control word
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_DISPATCH,
        SEQ_JUMP_IF_FOUND
    } seq_t;

    typedef struct packed {
        op_t   op;
        seq_t  seq;
        step_t target;
    } ctrl_t;

    // read-only control store
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        case (s)
            ST_IDLE:  w = '{op: OP_NONE,  seq: SEQ_DISPATCH,      target: ST_IDLE};
            ST_BYTE:  w = '{op: OP_BYTE,  seq: SEQ_JUMP,          target: ST_IDLE};
            ST_CLEAR: w = '{op: OP_CLEAR, seq: SEQ_JUMP,          target: ST_IDLE};
            ST_QINIT: w = '{op: OP_QINIT, seq: SEQ_NEXT,          target: ST_IDLE};
            ST_QTEST: w = '{op: OP_READ,  seq: SEQ_JUMP_IF_FOUND, target: ST_QDONE};
            ST_QCMP:  w = '{op: OP_CMP,   seq: SEQ_JUMP,          target: ST_QTEST};
            ST_QDONE: w = '{op: OP_DONE,  seq: SEQ_JUMP,          target: ST_IDLE};
            default:  w = '{op: OP_NONE,  seq: SEQ_JUMP,          target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/newline_index_line_lookup_top.sv
// ----------------------------------------------------------------------------
// newline_index_line_lookup_top
// records newline positions of a text and answers line number queries
// ----------------------------------------------------------------------------
// clear and byte words: busy from the accepting edge until the sequencer returns to idle, unused code for none
// query word: steps QINIT, then QTEST and QCMP for each search pass, then QDONE; done rises as busy falls,
//   with at most ceil(log2(newline count + 1)) <= 13 search passes of one registered ram read
//   and one compare each
// a new word is taken as soon as busy falls; results cannot be stalled
// rst_n clears count, byte position, overflow flag and sequencer, not the position ram
module newline_index_line_lookup_top
    import nlil_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic [7:0]          byte_value,
    input  logic [POS_BITS-1:0] query_position,
    output logic                done,
    output logic [CNT_BITS-1:0] line_number,
    output logic                table_overflowed
);

    // sequencer state
    step_t step_reg, step_next;
    ctrl_t ctrl;

    // text state
    logic [CNT_BITS-1:0] count_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic                ovf_reg;

    // search state
    logic [CNT_BITS-1:0] lo_reg, hi_reg;
    logic [CNT_BITS-1:0] mid_reg;
    logic [CNT_BITS-1:0] mid;
    logic [CNT_BITS-1:0] span;
    logic                found;

    // latched word
    logic [7:0]          byte_reg;
    logic [POS_BITS-1:0] query_reg;

    // result
    logic                done_reg;
    logic [CNT_BITS-1:0] line_reg;
    logic                ovf_out_reg;

    // position ram
    logic [POS_BITS-1:0] pos_mem [MAX_LINES];
    logic [POS_BITS-1:0] rd_data_reg;
    logic                mem_we;

    logic accept;

    assign busy   = (step_reg != ST_IDLE);
    assign accept = start && !busy;
    assign ctrl   = ucode(step_reg);

    // midpoint of the open search window, always below hi
    assign span  = hi_reg - lo_reg;
    assign mid   = lo_reg + (span >> 1);
    assign found = (lo_reg >= hi_reg);

    // a newline is stored only while the table has room
    assign mem_we = (ctrl.op == OP_BYTE) && (byte_reg == NEWLINE_BYTE)
                    && (count_reg < CNT_FULL);

    // ------------------------------------------------------------------
    // step counter: next step from the control word
    // ------------------------------------------------------------------
    always_comb
    begin
        step_next = step_reg;
        case (ctrl.seq)
            SEQ_NEXT:
            begin
                step_next = step_t'(step_reg + 3'd1);
            end
            SEQ_JUMP:
            begin
                step_next = ctrl.target;
            end
            SEQ_DISPATCH:
            begin
                // unused func code is taken and dropped
                if (accept)
                begin
                    case (func)
                        FUNC_CLEAR: step_next = ST_CLEAR;
                        FUNC_BYTE:  step_next = ST_BYTE;
                        FUNC_QUERY: step_next = ST_QINIT;
                        default:    step_next = ST_IDLE;
                    endcase
                end
            end
            SEQ_JUMP_IF_FOUND:
            begin
                step_next = found ? ctrl.target : step_t'(step_reg + 3'd1);
            end
            default:
            begin
                step_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // ------------------------------------------------------------------
    // control registers of the datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (ctrl.op)
                OP_CLEAR:
                begin
                    count_reg <= '0;
                    pos_reg   <= '0;
                    ovf_reg   <= 1'b0;
                end
                OP_BYTE:
                begin
                    if (byte_reg == NEWLINE_BYTE)
                    begin
                        if (count_reg < CNT_FULL)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    // position saturates at the top value
                    if (pos_reg != POS_MAX)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                OP_QINIT:
                begin
                    lo_reg <= '0;
                    hi_reg <= count_reg;
                end
                OP_CMP:
                begin
                    if (rd_data_reg < query_reg)
                    begin
                        lo_reg <= mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                end
                OP_DONE:
                begin
                    done_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= byte_value;
            query_reg <= query_position;
        end
        if (ctrl.op == OP_READ)
        begin
            mid_reg <= mid;
        end
        if (ctrl.op == OP_DONE)
        begin
            line_reg    <= lo_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    // ------------------------------------------------------------------
    // position ram: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[count_reg[ADDR_BITS-1:0]] <= pos_reg;
        end
        if ((ctrl.op == OP_READ) && !found)
        begin
            rd_data_reg <= pos_mem[mid[ADDR_BITS-1:0]];
        end
    end

    assign done             = done_reg;
    assign line_number      = line_reg;
    assign table_overflowed = ovf_out_reg;

`ifndef SYNTHESIS
    // search window never inverts
    assert property (@(posedge clk) disable iff (!rst_n) lo_reg <= hi_reg)
        else $error("search window inverted");

    // table count never passes its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("newline count beyond table depth");

    // a result only follows the final step of a search
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(step_reg) == ST_QDONE))
        else $error("result strobe without a finished search");

    // an accepted query keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_QUERY)) |=> busy)
        else $error("query accepted but block not busy");
`endif

endmodule

FILE: sim/tb_newline_index_line_lookup_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_newline_index_line_lookup_top
// self-checking bench for the newline position table and line number lookup
// ----------------------------------------------------------------------------
// drives clear, byte and query words over the start/busy handshake, keeps a
// private copy of the newline table to work out each line number, and checks
// every done strobe against the oldest pending line number; covers a directed
// table and random texts under several sender idle mixes
module tb_newline_index_line_lookup_top;
    import nlil_pkg::*;

    // func code with no meaning, the block must ignore it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // directed rows either carry a typed line number or defer to the predictor
    localparam logic EXP_TYPED     = 1'b1;
    localparam logic EXP_PREDICTED = 1'b0;

    localparam int RANDOM_PER_PHASE = 100;
    localparam int DRAIN_CYCLES     = 40;   // longest query takes 13 search passes
    localparam int DIRECTED_ROWS    = 24;

    typedef struct packed {
        logic [CNT_BITS-1:0] line;
        logic                overflowed;
    } line_result_t;

    typedef struct packed {
        logic [1:0]          f;
        logic [7:0]          b;
        logic [POS_BITS-1:0] q;
        logic                typed;
        logic [CNT_BITS-1:0] line;
        logic                overflowed;
    } stim_row_t;

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          func  = FUNC_CLEAR;
    logic [7:0]          byte_value     = 8'h00;
    logic [POS_BITS-1:0] query_position = '0;
    logic                busy;
    logic                done;
    logic [CNT_BITS-1:0] line_number;
    logic                table_overflowed;

    always #5 clk = ~clk;

    newline_index_line_lookup_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .byte_value       (byte_value),
        .query_position   (query_position),
        .done             (done),
        .line_number      (line_number),
        .table_overflowed (table_overflowed)
    );

    // ------------------------------------------------------------------
    // private copy of the text index
    // ------------------------------------------------------------------
    logic [POS_BITS-1:0] nl_table [MAX_LINES];
    int                  nl_count;
    logic [POS_BITS-1:0] text_pos;
    logic                dropped_flag;

    // line numbers still owed by the block, oldest first
    line_result_t pending_lines [$];

    int mismatch_count = 0;
    int words_accepted = 0;
    int lines_checked  = 0;

    // lower bound search: how many recorded newlines sit strictly below pos
    function automatic int newlines_below(input logic [POS_BITS-1:0] pos);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = nl_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (nl_table[mid] < pos)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // advance the index by one accepted word; returns 1 when a line number is due
    function automatic bit line_index_step(input logic [1:0] f,
                                           input logic [7:0] b,
                                           input logic [POS_BITS-1:0] q,
                                           output line_result_t res);
        res = '0;
        case (f)
            FUNC_CLEAR:
            begin
                nl_count     = 0;
                text_pos     = '0;
                dropped_flag = 1'b0;
                return 1'b0;
            end
            FUNC_BYTE:
            begin
                if (b == NEWLINE_BYTE)
                begin
                    // a full table drops the newline but remembers it happened
                    if (nl_count < MAX_LINES)
                    begin
                        nl_table[nl_count] = text_pos;
                        nl_count++;
                    end
                    else
                        dropped_flag = 1'b1;
                end
                // position sticks at the top once reached
                if (text_pos != POS_MAX)
                    text_pos = text_pos + 1'b1;
                return 1'b0;
            end
            FUNC_QUERY:
            begin
                res.line       = CNT_BITS'(newlines_below(q));
                res.overflowed = dropped_flag;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // word sender: optional idle gap, then hold start until busy is low
    // at an edge; the predictor runs at the accepting edge
    // ------------------------------------------------------------------
    task automatic send_word(input logic [1:0] f,
                             input logic [7:0] b,
                             input logic [POS_BITS-1:0] q,
                             input int gap,
                             input logic typed,
                             input logic [CNT_BITS-1:0] typed_line,
                             input logic typed_ovf);
        line_result_t res;
        bit           produced;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        func           <= f;
        byte_value     <= b;
        query_position <= q;
        // busy read here is the value the block saw at this edge
        do
            @(posedge clk);
        while (busy);
        words_accepted++;
        produced = line_index_step(f, b, q, res);
        if (produced)
        begin
            if (typed)
            begin
                res.line       = typed_line;
                res.overflowed = typed_ovf;
            end
            pending_lines = {pending_lines, res};
        end
    endtask

    // idle cycles before a word: each extra cycle taken with pct chance
    function automatic int idle_gap(input int pct);
        int n;
        n = 0;
        while (n < 20 && $urandom_range(99) < pct)
            n++;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // result checker: done is a one-cycle strobe, no back pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        line_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_lines.size() == 0)
                report_mismatch($sformatf("line number %0d with none pending", line_number));
            else
            begin
                exp_res = pending_lines.pop_front();
                lines_checked++;
                if (line_number !== exp_res.line)
                    report_mismatch($sformatf("line_number got %0d want %0d",
                                              line_number, exp_res.line));
                if (table_overflowed !== exp_res.overflowed)
                    report_mismatch($sformatf("table_overflowed got %0b want %0b",
                                              table_overflowed, exp_res.overflowed));
            end
        end
    end

    // ------------------------------------------------------------------
    // directed words: extremes, exact matches, ignored code, clears
    // ------------------------------------------------------------------
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty table right after reset
        '{FUNC_QUERY,  8'h00,        '0,           EXP_TYPED,     CNT_BITS'(0), 1'b0},
        '{FUNC_QUERY,  8'h00,        POS_MAX,      EXP_TYPED,     CNT_BITS'(0), 1'b0},
        // unused code carrying a newline must change nothing
        '{FUNC_UNUSED, NEWLINE_BYTE, POS_MAX,      EXP_PREDICTED, '0,           1'b0},
        // zero byte is plain content
        '{FUNC_BYTE,   8'h00,        '0,           EXP_PREDICTED, '0,           1'b0},
        '{FUNC_BYTE,   NEWLINE_BYTE, '0,           EXP_PREDICTED, '0,           1'b0},
        '{FUNC_BYTE,   8'hFF,        POS_MAX,      EXP_PREDICTED, '0,           1'b0},
        '{FUNC_BYTE,   NEWLINE_BYTE, '0,           EXP_PREDICTED, '0,           1'b0},
        '{FUNC_BYTE,   NEWLINE_BYTE, '0,           EXP_PREDICTED, '0,           1'b0},
        '{FUNC_BYTE,   8'h55,        '0,           EXP_PREDICTED, '0,           1'b0},
        '{FUNC_BYTE,   8'hAA,        '0,           EXP_PREDICTED, '0,           1'b0},
        // query on a newline's own position does not count it
        '{FUNC_QUERY,  8'h00,        20'd1,        EXP_PREDICTED, '0,           1'b0},
        '{FUNC_QUERY,  8'h00,        20'd2,        EXP_PREDICTED, '0,           1'b0},
        '{FUNC_QUERY,  8'hFF,        20'd0,        EXP_PREDICTED, '0,           1'b0},
        '{FUNC_QUERY,  8'h00,        20'd4,        EXP_PREDICTED, '0,           1'b0},
        '{FUNC_QUERY,  8'h00,        20'd5,        EXP_PREDICTED, '0,           1'b0},
        '{FUNC_QUERY,  8'h00,        POS_MAX,      EXP_TYPED,     CNT_BITS'(3), 1'b0},
        '{FUNC_UNUSED, NEWLINE_BYTE, '0,           EXP_PREDICTED, '0,           1'b0},
        '{FUNC_QUERY,  8'h00,        20'd5,        EXP_PREDICTED, '0,           1'b0},
        // clear empties the table
        '{FUNC_CLEAR,  8'hFF,        POS_MAX,      EXP_PREDICTED, '0,           1'b0},
        '{FUNC_QUERY,  8'h00,        POS_MAX,      EXP_TYPED,     CNT_BITS'(0), 1'b0},
        '{FUNC_BYTE,   NEWLINE_BYTE, '0,           EXP_PREDICTED, '0,           1'b0},
        '{FUNC_QUERY,  8'h00,        20'd0,        EXP_PREDICTED, '0,           1'b0},
        '{FUNC_QUERY,  8'h00,        20'd1,        EXP_PREDICTED, '0,           1'b0},
        '{FUNC_CLEAR,  8'h00,        '0,           EXP_PREDICTED, '0,           1'b0}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int                  idx;
        int                  phase;
        int                  idle_pct;
        int                  counted;
        int                  roll;
        int                  pick;
        logic [1:0]          f;
        logic [7:0]          b;
        logic [POS_BITS-1:0] q;

        nl_count     = 0;
        text_pos     = '0;
        dropped_flag = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < DIRECTED_ROWS; idx++)
            send_word(directed_rows[idx].f, directed_rows[idx].b, directed_rows[idx].q, 0,
                      directed_rows[idx].typed, directed_rows[idx].line,
                      directed_rows[idx].overflowed);

        // random texts: phase 0 no idling, 1 sender idle 57%, 2 no idling
        // (receiver cannot stall), 3 sender idle 27%
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 57;
                3:       idle_pct = 27;
                default: idle_pct = 0;
            endcase
            send_word(FUNC_CLEAR, 8'($urandom), POS_BITS'($urandom), idle_gap(idle_pct),
                      EXP_PREDICTED, '0, 1'b0);
            counted = 0;
            while (counted < RANDOM_PER_PHASE)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    f = FUNC_CLEAR;
                else if (roll < 8)
                    f = FUNC_UNUSED;
                else if (roll < 60)
                    f = FUNC_BYTE;
                else
                    f = FUNC_QUERY;
                // unused fields stay random too, the block must ignore them
                b = ($urandom_range(99) < 30) ? NEWLINE_BYTE : 8'($urandom_range(255));
                pick = $urandom_range(99);
                if (nl_count > 0 && pick < 40)
                    // around a recorded newline: just below, on it, just above
                    q = POS_BITS'(nl_table[$urandom_range(nl_count - 1)]
                                  + $urandom_range(2) - 1);
                else if (pick < 85)
                    q = POS_BITS'($urandom_range(int'(text_pos) + 2));
                else
                    q = POS_BITS'($urandom);
                send_word(f, b, q, idle_gap(idle_pct), EXP_PREDICTED, '0, 1'b0);
                if (f != FUNC_UNUSED)
                    counted++;
            end
        end

        start <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d words and %0d checked line numbers", words_accepted,
                 lines_checked);
        $display("including empty tables, exact newline hits and random texts with idle gaps");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d line numbers pending", pending_lines.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
